// File: hdl/box_blur_3x3_stream_assert.svh
// Assertion macros for the 3x3 box blur.
`ifndef BOX_BLUR_3X3_STREAM_ASSERT_SVH
`define BOX_BLUR_3X3_STREAM_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BB3_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BB3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/bb3_pkg.sv
package bb3_pkg;

    localparam int PIX_W      = 8;
    localparam int SUM_W      = 12;
    localparam int ROW_OUT_W  = 12;
    localparam int COL_OUT_W  = 11;
    localparam int COLS_CFG_W = 12;
    localparam int ROWS_CFG_W = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int SIZE_W     = 17;
    localparam int MIN_SIZE   = 3;
    localparam int WIN_REGS   = 6;
    localparam int WIN_TAPS   = 3 * 3;

    // floor(x/9) == (x*RECIP_9) >> RECIP_SHIFT for all x < 32768
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 13;
    localparam int RECIP_9     = (1 << RECIP_SHIFT) / WIN_TAPS + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam logic [CFG_IDX_W-1:0]  CFG_NUM_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_NUM_ROWS = 1'd1;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET   = 12'd500;
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET   = 13'd288;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        t_pix older;
        t_pix newer;
    } t_line_pair;

    typedef struct packed {
        logic busy;
    } t_ls_status;

endpackage

// File: hdl/bb3_line_store.sv
module bb3_line_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output bb3_pkg::t_line_pair o_rd_data,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  bb3_pkg::t_line_pair i_wr_data,
    output bb3_pkg::t_ls_status o_status
);
    import bb3_pkg::*;

    t_line_pair mem [DEPTH];
    t_line_pair r_q;
    logic       r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // clearing pass after reset, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= mem[i_rd_addr];
        end
    end

    assign o_rd_data       = r_q;
    assign o_status.busy   = r_clr_busy;

endmodule

// File: hdl/box_blur_3x3_stream.sv
// 3x3 box blur, 8-bit grayscale, raster-order stream.
// Input channel: i_valid / o_ready carry one source pixel per beat.
// Output channel: o_valid / i_ready carry one blurred pixel per beat with its
// row and column; every input beat yields exactly one output beat, which is
// the pixel num_cols+1 positions earlier in raster order. Border pixels are 0.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_idx (0: num_cols,
// 1: num_rows); write only while the block is idle.
// Throughput: one pixel per cycle while the output is not stalled and no clearing
// pass runs. The two line stores share one memory with a registered read; each
// pixel reads and writes back one entry. Pipeline: read stage, sum stage,
// divide-by-9 stage.
// Reset: counters and window clear, then a clearing pass writes zero to all
// MAX_COLS line-store entries, one per cycle; o_ready stays low until the pass
// ends. Config writes are taken during the pass.
// Receiver stall: the three stages fill, then o_ready drops; nothing is lost.
module box_blur_3x3_stream #(
    parameter int MAX_COLS = 2048,
    parameter int MAX_ROWS = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [bb3_pkg::PIX_W-1:0]        i_pixel_in,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [bb3_pkg::PIX_W-1:0]        o_pixel_out,
    output logic [bb3_pkg::ROW_OUT_W-1:0]    o_out_row,
    output logic [bb3_pkg::COL_OUT_W-1:0]    o_out_col,
    input  logic                             i_cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bb3_pkg::*;

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);

    // config
    logic [COLS_CFG_W-1:0] r_num_cols;
    logic [ROWS_CFG_W-1:0] r_num_rows;
    logic [SIZE_W-1:0]     cols_ext, rows_ext, w_full, h_full;
    logic [CW:0]           w;
    logic [RW:0]           h;

    // counters and position
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW:0]   c_ext, c_nxt, ocol;
    logic [RW:0]   r_ext, r_nxt, orow;
    logic          interior;

    // handshake
    logic go1, go2, go3, acc, mv1, mv2;
    t_ls_status ls_status;

    // stage 1
    logic                 r_v1, r_int1;
    t_pix                 r_px1;
    logic [CW-1:0]        r_idx1;
    logic [ROW_OUT_W-1:0] r_orow1;
    logic [COL_OUT_W-1:0] r_ocol1;
    t_line_pair           ls_q, ls_wdata;
    t_pix                 r_win [WIN_REGS];
    logic [SUM_W-1:0]     sum1;

    // stage 2
    logic                 r_v2;
    logic [SUM_W-1:0]     r_sum2;
    logic [ROW_OUT_W-1:0] r_orow2;
    logic [COL_OUT_W-1:0] r_ocol2;
    logic [PROD_W-1:0]    prod;

    // stage 3 / output
    logic                 r_v3;
    t_pix                 r_pix3;
    logic [ROW_OUT_W-1:0] r_orow3;
    logic [COL_OUT_W-1:0] r_ocol3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= COLS_RESET;
            r_num_rows <= ROWS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NUM_COLS: r_num_cols <= i_cfg_data[COLS_CFG_W-1:0];
                CFG_NUM_ROWS: r_num_rows <= i_cfg_data[ROWS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cols_ext = SIZE_W'(r_num_cols);
        rows_ext = SIZE_W'(r_num_rows);
        priority if (cols_ext < SIZE_W'(MIN_SIZE)) begin
            w_full = SIZE_W'(MIN_SIZE);
        end else if (cols_ext > SIZE_W'(MAX_COLS)) begin
            w_full = SIZE_W'(MAX_COLS);
        end else begin
            w_full = cols_ext;
        end
        priority if (rows_ext < SIZE_W'(MIN_SIZE)) begin
            h_full = SIZE_W'(MIN_SIZE);
        end else if (rows_ext > SIZE_W'(MAX_ROWS)) begin
            h_full = SIZE_W'(MAX_ROWS);
        end else begin
            h_full = rows_ext;
        end
        w = w_full[CW:0];
        h = h_full[RW:0];
    end

    always_comb begin
        c_ext = {1'b0, r_col};
        r_ext = {1'b0, r_row};
        c_nxt = c_ext + (CW+1)'(1);
        r_nxt = r_ext + (RW+1)'(1);
        interior = (r_ext >= (RW+1)'(2)) && (r_ext < h) &&
                   (c_ext >= (CW+1)'(2)) && (c_ext < w);
        if (c_ext != '0) begin
            ocol = c_ext - (CW+1)'(1);
            orow = (r_ext >= (RW+1)'(1)) ? r_ext - (RW+1)'(1) : h - (RW+1)'(1);
        end else begin
            ocol = w - (CW+1)'(1);
            orow = (r_ext >= (RW+1)'(2)) ? r_ext - (RW+1)'(2)
                                         : r_ext + h - (RW+1)'(2);
        end
    end

    assign go3     = !r_v3 || i_ready;
    assign go2     = !r_v2 || go3;
    assign go1     = !r_v1 || go2;
    assign o_ready = go1 && !ls_status.busy;
    assign acc     = i_valid && o_ready;
    assign mv1     = r_v1 && go2;
    assign mv2     = r_v2 && go3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            if (c_nxt >= w) begin
                r_col <= '0;
                r_row <= (r_nxt >= h) ? '0 : r_nxt[RW-1:0];
            end else begin
                r_col <= c_nxt[CW-1:0];
            end
        end
    end

    bb3_line_store #(
        .DEPTH (MAX_COLS),
        .AW    (CW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (acc),
        .i_rd_addr (r_col),
        .o_rd_data (ls_q),
        .i_wr_en   (mv1),
        .i_wr_addr (r_idx1),
        .i_wr_data (ls_wdata),
        .o_status  (ls_status)
    );

    // older row takes the old newer row, newer row takes the current pixel
    assign ls_wdata.older = ls_q.newer;
    assign ls_wdata.newer = r_px1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (go1) r_v1 <= acc;
            if (go2) r_v2 <= r_v1;
            if (go3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_px1   <= i_pixel_in;
            r_idx1  <= r_col;
            r_int1  <= interior;
            r_orow1 <= ROW_OUT_W'(orow);
            r_ocol1 <= COL_OUT_W'(ocol);
        end
    end

    always_comb begin
        sum1 = SUM_W'(ls_q.older) + SUM_W'(ls_q.newer) + SUM_W'(r_px1);
        for (int k = 0; k < WIN_REGS; k++) begin
            sum1 = sum1 + SUM_W'(r_win[k]);
        end
    end

    // window: 0..2 hold column c-1, 3..5 column c-2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN_REGS; k++) begin
                r_win[k] <= '0;
            end
        end else if (mv1) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= ls_q.older;
            r_win[1] <= ls_q.newer;
            r_win[2] <= r_px1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv1) begin
            r_sum2  <= r_int1 ? sum1 : '0;
            r_orow2 <= r_orow1;
            r_ocol2 <= r_ocol1;
        end
    end

    assign prod = PROD_W'(r_sum2) * PROD_W'(RECIP_9);

    always_ff @(posedge i_clk) begin
        if (mv2) begin
            r_pix3  <= prod[RECIP_SHIFT +: PIX_W];
            r_orow3 <= r_orow2;
            r_ocol3 <= r_ocol2;
        end
    end

    assign o_valid     = r_v3;
    assign o_pixel_out = r_pix3;
    assign o_out_row   = r_orow3;
    assign o_out_col   = r_ocol3;

`include "box_blur_3x3_stream_assert.svh"

    `BB3_ASSERT_IMP(a_no_accept_clear, i_clk, i_rst_n, ls_status.busy, !o_ready, "beat accepted during line store clear")
    `BB3_ASSERT_IMP(a_no_rw_clash, i_clk, i_rst_n, acc && mv1, r_col != r_idx1, "line store read and write hit same entry")
    `BB3_ASSERT_IMP(a_col0_border, i_clk, i_rst_n, o_valid && (o_out_col == '0), o_pixel_out == '0, "nonzero pixel in first column")
    `BB3_ASSERT_IMP(a_row0_border, i_clk, i_rst_n, o_valid && (o_out_row == '0), o_pixel_out == '0, "nonzero pixel in first row")
    `BB3_ASSERT_NEXT(a_s1_fill, i_clk, i_rst_n, acc, r_v1, "accepted beat missing from first stage")

endmodule
